// ===== sv/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, commands and status codes for the periodic/one-shot timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int TICK_BITS = 48;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TICK_BITS-1:0] tick_t;

	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_CREATE  = 3'd1;
	localparam logic [2:0] CMD_START   = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_DESTROY = 3'd4;

	localparam logic [2:0] STAT_DONE  = 3'd0;
	localparam logic [2:0] STAT_FIRED = 3'd1;
	localparam logic [2:0] STAT_NONE  = 3'd2;
	localparam logic [2:0] STAT_BUSY  = 3'd3;
	localparam logic [2:0] STAT_EMPTY = 3'd4;

	// one entry of the slot memory
	typedef struct packed {
		logic        periodic;
		logic [31:0] interval;
		tick_t       expiry;
		logic [31:0] count;
	} slot_rec_t;

endpackage

// ===== sv/periodic_oneshot_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank
// Table of timer slots kept in a synchronous memory; a tick scans all slots.
// ----------------------------------------------------------------------------
// Create, start, stop and destroy are handled in the idle state; the result is in
// the output register in the cycle after the command is accepted. A tick scans one
// slot per cycle through the slot memory's read port while the output side does
// not stall. Reset clears used/enable flags, the tick counter and all valid flags;
// the slot memory itself is not cleared.
module periodic_oneshot_timer_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [3:0]  timer_slot,
	input  logic [31:0] interval_ticks,
	input  logic        is_periodic,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot_index,
	output logic [31:0] times_fired,
	output logic        last_of_run
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q;

	logic [ptb_pkg::NUM_SLOTS-1:0] used_q;
	logic [ptb_pkg::NUM_SLOTS-1:0] enabled_q;

	ptb_pkg::tick_t tick_now_q;
	ptb_pkg::tick_t tick_old_q;

	ptb_pkg::slot_rec_t mem [ptb_pkg::NUM_SLOTS];

	ptb_pkg::cnt_t      rd_idx_q;
	logic               ev_valid_s2;
	ptb_pkg::slot_t     ev_idx_s2;
	ptb_pkg::slot_rec_t rd_data_s2;

	logic           pend_valid_q;
	ptb_pkg::slot_t pend_idx_q;
	logic [31:0]    pend_count_q;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [3:0]  slot_index_q;
	logic [31:0] times_fired_q;
	logic        last_of_run_q;

	logic               in_fire;
	logic               out_free;
	logic               req_ok;
	ptb_pkg::slot_t     req_idx;
	logic               req_used;
	logic               scan_end;
	logic               fire2;
	logic               need_push;
	logic               adv;
	logic               rd_en;
	ptb_pkg::slot_t     rd_addr;
	logic               mem_we;
	ptb_pkg::slot_t     wr_addr;
	ptb_pkg::slot_rec_t wr_data;
	ptb_pkg::slot_rec_t fired_rec;
	logic               push;
	logic [2:0]         push_status;
	logic [3:0]         push_idx;
	logic [31:0]        push_count;
	logic               push_last;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_fire  = in_valid && !in_stall;

	assign req_ok   = 32'(timer_slot) < 32'(ptb_pkg::NUM_SLOTS);
	assign req_idx  = ptb_pkg::slot_t'(timer_slot);
	assign req_used = req_ok && used_q[req_idx];

	// scan pipeline: read issued for rd_idx_q, data for ev_idx_s2 evaluated
	assign scan_end = (state_q == S_SCAN) && !ev_valid_s2
		&& (rd_idx_q == ptb_pkg::cnt_t'(ptb_pkg::NUM_SLOTS));
	assign fire2 = (state_q == S_SCAN) && ev_valid_s2 && used_q[ev_idx_s2]
		&& enabled_q[ev_idx_s2] && (rd_data_s2.expiry <= tick_old_q);
	// a new firing pushes the held one out, so its last flag is known
	assign need_push = (fire2 && pend_valid_q) || scan_end;
	assign adv       = !need_push || out_free;

	assign rd_en   = (state_q == S_SCAN) && adv
		&& (rd_idx_q < ptb_pkg::cnt_t'(ptb_pkg::NUM_SLOTS));
	assign rd_addr = rd_idx_q[ptb_pkg::SLOT_W-1:0];

	always_comb begin
		fired_rec = rd_data_s2;
		if (rd_data_s2.count != 32'hFFFF_FFFF) begin
			fired_rec.count = rd_data_s2.count + 32'd1;
		end
		if (rd_data_s2.periodic) begin
			fired_rec.expiry = tick_old_q + ptb_pkg::tick_t'(rd_data_s2.interval);
		end
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = req_idx;
		wr_data = '{periodic: is_periodic, interval: interval_ticks,
			expiry: '0, count: '0};
		if (state_q == S_SCAN) begin
			mem_we  = fire2 && adv;
			wr_addr = ev_idx_s2;
			wr_data = fired_rec;
		end else if (in_fire && cmd == ptb_pkg::CMD_CREATE && req_ok && !req_used) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		push        = 1'b0;
		push_status = ptb_pkg::STAT_DONE;
		push_idx    = timer_slot;
		push_count  = '0;
		push_last   = 1'b1;
		if (state_q == S_IDLE) begin
			if (in_fire) begin
				unique case (cmd) inside
					ptb_pkg::CMD_CREATE: begin
						push        = 1'b1;
						push_status = req_used || !req_ok ? ptb_pkg::STAT_BUSY
							: ptb_pkg::STAT_DONE;
					end
					ptb_pkg::CMD_START, ptb_pkg::CMD_STOP, ptb_pkg::CMD_DESTROY: begin
						push        = 1'b1;
						push_status = req_used ? ptb_pkg::STAT_DONE : ptb_pkg::STAT_EMPTY;
					end
					default: push = 1'b0;
				endcase
			end
		end else if (need_push && out_free) begin
			push        = 1'b1;
			push_idx    = 4'(pend_idx_q);
			push_count  = pend_count_q;
			push_last   = scan_end;
			push_status = ptb_pkg::STAT_FIRED;
			if (!pend_valid_q) begin
				push_status = ptb_pkg::STAT_NONE;
				push_idx    = '0;
				push_count  = '0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			enabled_q    <= '0;
			tick_now_q   <= '0;
			rd_idx_q     <= '0;
			ev_valid_s2  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE) begin
				if (in_fire) begin
					unique case (cmd)
						ptb_pkg::CMD_TICK: begin
							tick_now_q <= tick_now_q + ptb_pkg::tick_t'(1);
							rd_idx_q   <= '0;
							state_q    <= S_SCAN;
						end
						ptb_pkg::CMD_CREATE: begin
							if (req_ok && !req_used) begin
								used_q[req_idx]    <= 1'b1;
								enabled_q[req_idx] <= 1'b0;
							end
						end
						ptb_pkg::CMD_START: begin
							if (req_used) enabled_q[req_idx] <= 1'b1;
						end
						ptb_pkg::CMD_STOP: begin
							if (req_used) enabled_q[req_idx] <= 1'b0;
						end
						ptb_pkg::CMD_DESTROY: begin
							if (req_used) begin
								used_q[req_idx]    <= 1'b0;
								enabled_q[req_idx] <= 1'b0;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
			end else if (adv) begin
				ev_valid_s2 <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + ptb_pkg::cnt_t'(1);
				end
				if (fire2) begin
					pend_valid_q <= 1'b1;
					if (!rd_data_s2.periodic) begin
						enabled_q[ev_idx_s2] <= 1'b0;
					end
				end
				if (scan_end) begin
					pend_valid_q <= 1'b0;
					state_q      <= S_IDLE;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire && cmd == ptb_pkg::CMD_TICK) begin
			tick_old_q <= tick_now_q;
		end
		if (state_q == S_SCAN && adv) begin
			ev_idx_s2 <= rd_addr;
			if (fire2) begin
				pend_idx_q   <= ev_idx_s2;
				pend_count_q <= fired_rec.count;
			end
		end
		if (push) begin
			status_q      <= push_status;
			slot_index_q  <= push_idx;
			times_fired_q <= push_count;
			last_of_run_q <= push_last;
		end
	end

	// slot memory with a registered read port; read data holds while the scan waits
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s2 <= mem[rd_addr];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_index  = slot_index_q;
	assign times_fired = times_fired_q;
	assign last_of_run = last_of_run_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q && !ev_valid_s2)
		else $error("held firing or scan data outside a tick scan");

	a_tick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == ptb_pkg::CMD_TICK |=> state_q == S_SCAN && rd_idx_q == '0)
		else $error("tick did not start a scan at slot zero");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && rd_en |-> wr_addr != rd_addr)
		else $error("slot memory read and written at the same entry");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into an occupied output register");

	a_scan_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && scan_end && out_free |=> out_valid_q && last_of_run_q)
		else $error("scan ended without a final result");

endmodule

// ===== tb/periodic_oneshot_timer_bank_test.sv =====
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank_test
// Self-checking testbench for the periodic/one-shot timer bank.
// ----------------------------------------------------------------------------
// A shadow copy of the slot table predicts the transactions that each command
// causes. Each result is checked field by field against the oldest prediction.
// Directed tests cover the corner cases. A random phase then runs create,
// start, tick, stop, destroy and reserved-code sequences with random content,
// under random gaps on the sender and random stalls on the receiver.
module periodic_oneshot_timer_bank_test;
	timeunit 1ns;
	timeprecision 1ps;

	// reserved command codes; the bank ignores them
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	localparam int DRAIN_CYCLES = 2 * ptb_pkg::NUM_SLOTS + 8;

	typedef struct packed {
		logic [2:0]      st;
		ptb_pkg::slot_t  slot;
		logic [31:0]     count;
		logic            last;
	} timer_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  cmd;
	logic [3:0]  timer_slot;
	logic [31:0] interval_ticks;
	logic        is_periodic;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [3:0]  slot_index;
	logic [31:0] times_fired;
	logic        last_of_run;

	// shadow slot table
	logic           shadow_used     [ptb_pkg::NUM_SLOTS];
	logic           shadow_enabled  [ptb_pkg::NUM_SLOTS];
	logic           shadow_periodic [ptb_pkg::NUM_SLOTS];
	logic [31:0]    shadow_interval [ptb_pkg::NUM_SLOTS];
	ptb_pkg::tick_t shadow_expiry   [ptb_pkg::NUM_SLOTS];
	logic [31:0]    shadow_count    [ptb_pkg::NUM_SLOTS];
	ptb_pkg::tick_t shadow_now;

	timer_result_t pending_results[$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int n_sent;
	int n_checked;
	int n_firings;
	int busiest_tick;
	int n_errors;

	periodic_oneshot_timer_bank dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.cmd,
		.timer_slot,
		.interval_ticks,
		.is_periodic,
		.out_valid,
		.out_stall,
		.status,
		.slot_index,
		.times_fired,
		.last_of_run
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Apply one accepted command to the shadow table and queue its results.
	task automatic predict_command(input logic [2:0] c, input logic [3:0] sl,
			input logic [31:0] iv, input logic per);
		int unsigned    s;
		bit             ok;
		ptb_pkg::tick_t old;
		int             fired;
		int             i;
		timer_result_t  r;
		s = 32'(sl);
		ok = (s < ptb_pkg::NUM_SLOTS);
		r = '{ptb_pkg::STAT_DONE, ptb_pkg::slot_t'(sl), 32'd0, 1'b1};
		case (c) inside
		ptb_pkg::CMD_TICK: begin
			old = shadow_now;
			shadow_now = old + 1'b1;
			fired = 0;
			for (i = 0; i < ptb_pkg::NUM_SLOTS; i++) begin
				if (shadow_used[i] && shadow_enabled[i] && shadow_expiry[i] <= old) begin
					// hold back the previous firing until we know it is not the last
					if (fired != 0)
						pending_results.push_back(r);
					if (shadow_count[i] != '1)
						shadow_count[i]++;
					if (shadow_periodic[i])
						shadow_expiry[i] = old + ptb_pkg::tick_t'(shadow_interval[i]);
					else
						shadow_enabled[i] = 1'b0;
					r = '{ptb_pkg::STAT_FIRED, ptb_pkg::slot_t'(i), shadow_count[i], 1'b0};
					fired++;
				end
			end
			if (fired == 0)
				r = '{ptb_pkg::STAT_NONE, ptb_pkg::slot_t'(0), 32'd0, 1'b1};
			else
				r.last = 1'b1;
			n_firings += fired;
			if (fired > busiest_tick)
				busiest_tick = fired;
		end
		ptb_pkg::CMD_CREATE: begin
			if (!ok || shadow_used[s]) begin
				r.st = ptb_pkg::STAT_BUSY;
			end else begin
				shadow_used[s]     = 1'b1;
				shadow_enabled[s]  = 1'b0;
				shadow_periodic[s] = per;
				shadow_interval[s] = iv;
				shadow_expiry[s]   = '0;
				shadow_count[s]    = '0;
			end
		end
		ptb_pkg::CMD_START, ptb_pkg::CMD_STOP, ptb_pkg::CMD_DESTROY: begin
			if (!ok || !shadow_used[s]) begin
				r.st = ptb_pkg::STAT_EMPTY;
			end else if (c == ptb_pkg::CMD_START) begin
				shadow_enabled[s] = 1'b1;
			end else if (c == ptb_pkg::CMD_STOP) begin
				shadow_enabled[s] = 1'b0;
			end else begin
				shadow_used[s]    = 1'b0;
				shadow_enabled[s] = 1'b0;
			end
		end
		default: return;
		endcase
		pending_results.push_back(r);
	endtask

	task automatic send_cmd(input logic [2:0] c, input logic [3:0] sl = '0,
			input logic [31:0] iv = '0, input logic per = 1'b0);
		int gap;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		cmd            <= c;
		timer_slot     <= sl;
		interval_ticks <= iv;
		is_periodic    <= per;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_command(c, sl, iv, per);
		n_sent++;
	endtask

	// Hold off new commands until every predicted result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [3:0] pick_slot(input bit want_used);
		int cand[$];
		for (int i = 0; i < ptb_pkg::NUM_SLOTS; i++)
			if (shadow_used[i] == want_used)
				cand.push_back(i);
		if (cand.size() == 0 || $urandom_range(0, 99) < 15)
			return 4'($urandom);
		return 4'(cand[$urandom_range(0, cand.size() - 1)]);
	endfunction

	function automatic logic [31:0] draw_interval();
		case ($urandom_range(0, 9))
		0:       return '1;
		1, 2:    return $urandom;
		default: return $urandom_range(0, 4);
		endcase
	endfunction

	task automatic test_empty_table();
		send_cmd(ptb_pkg::CMD_TICK);
		send_cmd(ptb_pkg::CMD_START, 4'd3);
		send_cmd(ptb_pkg::CMD_STOP, 4'd15);
		send_cmd(ptb_pkg::CMD_DESTROY, 4'd0);
	endtask

	task automatic test_create_busy();
		send_cmd(ptb_pkg::CMD_CREATE, 4'd0, 32'd0, 1'b1);
		// second create on a used slot must leave it untouched
		send_cmd(ptb_pkg::CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b0);
		send_cmd(ptb_pkg::CMD_CREATE, 4'd15, 32'hFFFF_FFFF, 1'b0);
		send_cmd(ptb_pkg::CMD_CREATE, 4'd7, 32'hFFFF_FFFF, 1'b1);
	endtask

	task automatic test_reserved_cmds();
		send_cmd(CMD_RSVD_5, 4'($urandom), $urandom, 1'($urandom));
		send_cmd(CMD_RSVD_6, 4'($urandom), $urandom, 1'($urandom));
		send_cmd(CMD_RSVD_7, 4'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic test_fire_kinds();
		send_cmd(ptb_pkg::CMD_START, 4'd0);
		send_cmd(ptb_pkg::CMD_START, 4'd15);
		send_cmd(ptb_pkg::CMD_START, 4'd7);
		send_cmd(ptb_pkg::CMD_TICK);
		send_cmd(ptb_pkg::CMD_TICK);
		send_cmd(ptb_pkg::CMD_STOP, 4'd0);
		send_cmd(ptb_pkg::CMD_TICK);
		// restart a one-shot that already fired
		send_cmd(ptb_pkg::CMD_START, 4'd15);
		send_cmd(ptb_pkg::CMD_TICK);
	endtask

	task automatic test_teardown();
		send_cmd(ptb_pkg::CMD_DESTROY, 4'd0);
		send_cmd(ptb_pkg::CMD_DESTROY, 4'd7);
		send_cmd(ptb_pkg::CMD_DESTROY, 4'd15);
		send_cmd(ptb_pkg::CMD_CREATE, 4'd0, 32'd5, 1'b0);
		send_cmd(ptb_pkg::CMD_DESTROY, 4'd0);
	endtask

	task automatic test_all_slots_fire();
		int i;
		for (i = 0; i < ptb_pkg::NUM_SLOTS; i++)
			if (shadow_used[i])
				send_cmd(ptb_pkg::CMD_DESTROY, 4'(i));
		for (i = 0; i < ptb_pkg::NUM_SLOTS; i++)
			send_cmd(ptb_pkg::CMD_CREATE, 4'(i), i[0] ? 32'(i) : 32'd0, ~i[0]);
		for (i = 0; i < ptb_pkg::NUM_SLOTS; i++)
			send_cmd(ptb_pkg::CMD_START, 4'(i));
		repeat (3)
			send_cmd(ptb_pkg::CMD_TICK, 4'($urandom), $urandom, 1'($urandom));
		for (i = 0; i < ptb_pkg::NUM_SLOTS; i++)
			send_cmd(ptb_pkg::CMD_DESTROY, 4'(i));
		wait_idle();
	endtask

	task automatic test_random_traffic(input int n_items);
		int          k;
		int          pick;
		logic [31:0] iv;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end
			if (k == n_items / 2)
				wait_idle();
			pick = $urandom_range(0, 99);
			iv = draw_interval();
			if (pick < 38)
				send_cmd(ptb_pkg::CMD_TICK, 4'($urandom), $urandom, 1'($urandom));
			else if (pick < 54)
				send_cmd(ptb_pkg::CMD_CREATE, pick_slot(1'b0), iv, 1'($urandom));
			else if (pick < 74)
				send_cmd(ptb_pkg::CMD_START, pick_slot(1'b1), iv, 1'($urandom));
			else if (pick < 84)
				send_cmd(ptb_pkg::CMD_STOP, pick_slot(1'b1), iv, 1'($urandom));
			else if (pick < 94)
				send_cmd(ptb_pkg::CMD_DESTROY, pick_slot(1'b1), iv, 1'($urandom));
			else
				send_cmd(ptb_pkg::CMD_DESTROY + 3'($urandom_range(1, 3)), 4'($urandom),
					iv, 1'($urandom));
		end
	endtask

	initial begin : result_stall_driver
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = rx_idle ? $urandom_range(0, 16) : 0;
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : result_monitor
		timer_result_t want;
		if (arst_n === 1'b1 && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction: status %0d slot %0d count %0d last %0d",
					$time, status, slot_index, times_fired, last_of_run);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (status !== want.st) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.st, status);
					n_errors++;
				end
				if (slot_index !== want.slot) begin
					$display("%0t: slot_index mismatch: expected %0d, actual %0d",
						$time, want.slot, slot_index);
					n_errors++;
				end
				if (times_fired !== want.count) begin
					$display("%0t: times_fired mismatch: expected %0d, actual %0d",
						$time, want.count, times_fired);
					n_errors++;
				end
				if (last_of_run !== want.last) begin
					$display("%0t: last_of_run mismatch: expected %0d, actual %0d",
						$time, want.last, last_of_run);
					n_errors++;
				end
			end
		end
	end

	initial begin : run_sequence
		for (int i = 0; i < ptb_pkg::NUM_SLOTS; i++) begin
			shadow_used[i]     = 1'b0;
			shadow_enabled[i]  = 1'b0;
			shadow_periodic[i] = 1'b0;
			shadow_interval[i] = '0;
			shadow_expiry[i]   = '0;
			shadow_count[i]    = '0;
		end
		shadow_now = '0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		cmd            <= ptb_pkg::CMD_TICK;
		timer_slot     <= '0;
		interval_ticks <= '0;
		is_periodic    <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_create_busy();
		test_reserved_cmds();
		test_fire_kinds();
		wait_idle();
		test_teardown();
		test_all_slots_fire();
		test_random_traffic(120);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		n_errors += pending_results.size();

		$display("Sent %0d commands; %0d results compared, %0d of them timer firings.",
			n_sent, n_checked, n_firings);
		$display("Busiest tick fired %0d slots; tick counter ended at %0d.",
			busiest_tick, shadow_now);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
